### hdl/amount_to_spoken_words_defines.svh
// Assertion helpers shared by the checking code of the amount announcer.
// Each macro expands to one labeled concurrent assertion on clk, held off
// while rst is high.
`ifndef AMOUNT_TO_SPOKEN_WORDS_DEFINES_SVH
`define AMOUNT_TO_SPOKEN_WORDS_DEFINES_SVH

// Same-cycle implication: whenever cond holds, prop holds too.
`define ATSW_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication: whenever cond holds, prop holds in the next cycle.
`define ATSW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hdl/atsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atsw_pkg;

  // Field widths
  localparam int AMOUNT_W = 14;
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 10;

  // Largest amount that is spelled out
  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 14'd9999;

  // Clip kinds
  localparam logic [KIND_W-1:0] KIND_NUMERAL     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FEM_NUMERAL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_THOUSAND    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CURRENCY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW    = 3'd4;

  // Noun forms
  localparam logic [VALUE_W-1:0] FORM_NOM_SING = 10'd0;
  localparam logic [VALUE_W-1:0] FORM_GEN_SING = 10'd1;
  localparam logic [VALUE_W-1:0] FORM_GEN_PLUR = 10'd2;

  // Fixed clip slots, in playback order
  localparam int SLOT_COUNT   = 6;
  localparam int SLOT_TH_NUM  = 0;
  localparam int SLOT_TH_NOUN = 1;
  localparam int SLOT_HUND    = 2;
  localparam int SLOT_TENS    = 3;
  localparam int SLOT_UNITS   = 4;
  localparam int SLOT_NOUN    = 5;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
  } slot_t;

  // One decoded amount: a presence mask and the clip held in each slot
  typedef struct packed {
    logic [SLOT_COUNT-1:0] mask;
    slot_t [SLOT_COUNT-1:0] slot;
  } list_t;

endpackage

`default_nettype wire

### hdl/atsw_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module atsw_decode (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [atsw_pkg::AMOUNT_W-1:0]  amount,
  input  wire logic                           amount_valid,
  output logic                                amount_ready,
  output atsw_pkg::list_t                     list,
  output logic                                list_valid,
  input  wire logic                           list_ready
);
  import atsw_pkg::*;

  logic [AMOUNT_W-1:0] amt;
  logic                amt_full;

  logic [3:0]          th;
  logic [3:0]          hu;
  logic [3:0]          te;
  logic [3:0]          un;
  logic [AMOUNT_W-1:0] rem1;
  logic [AMOUNT_W-1:0] rem2;
  logic [AMOUNT_W-1:0] rem3;

  // Count how many multiples of step fit under val (nine independent compares)
  function automatic logic [3:0] split_digit(input logic [AMOUNT_W-1:0] val,
                                             input logic [AMOUNT_W-1:0] step);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (val >= AMOUNT_W'(k) * step) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  // Pick the noun form from the last two digits
  function automatic logic [VALUE_W-1:0] noun_form(input logic [3:0] tens,
                                                   input logic [3:0] units);
    logic [VALUE_W-1:0] f;
    if (tens == 4'd1) begin
      f = FORM_GEN_PLUR;
    end else if (units == 4'd1) begin
      f = FORM_NOM_SING;
    end else if (units >= 4'd2 && units <= 4'd4) begin
      f = FORM_GEN_SING;
    end else begin
      f = FORM_GEN_PLUR;
    end
    return f;
  endfunction

  // Hold the input until the list stage can take it
  assign amount_ready = !amt_full || list_ready;
  assign list_valid   = amt_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      amt_full <= 1'b0;
    end else if (amount_ready) begin
      amt_full <= amount_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (amount_valid && amount_ready) begin
      amt <= amount;
    end
  end

  // Split into decimal digits, one compare set and subtract per digit
  always_comb begin
    th   = split_digit(amt, 14'd1000);
    rem1 = amt - AMOUNT_W'(th) * 14'd1000;
    hu   = split_digit(rem1, 14'd100);
    rem2 = rem1 - AMOUNT_W'(hu) * 14'd100;
    te   = split_digit(rem2, 14'd10);
    rem3 = rem2 - AMOUNT_W'(te) * 14'd10;
    un   = rem3[3:0];
  end

  // Fill the clip slots
  always_comb begin
    list = '0;
    if (amt > AMOUNT_MAX) begin
      list.mask[SLOT_NOUN]       = 1'b1;
      list.slot[SLOT_NOUN].kind  = KIND_OVERFLOW;
      list.slot[SLOT_NOUN].value = '0;
    end else begin
      list.mask[SLOT_TH_NUM]        = (th != 4'd0);
      list.slot[SLOT_TH_NUM].kind   = (th <= 4'd2) ? KIND_FEM_NUMERAL : KIND_NUMERAL;
      list.slot[SLOT_TH_NUM].value  = VALUE_W'(th);

      list.mask[SLOT_TH_NOUN]       = (th != 4'd0);
      list.slot[SLOT_TH_NOUN].kind  = KIND_THOUSAND;
      list.slot[SLOT_TH_NOUN].value = noun_form(4'd0, th);

      list.mask[SLOT_HUND]          = (hu != 4'd0);
      list.slot[SLOT_HUND].kind     = KIND_NUMERAL;
      list.slot[SLOT_HUND].value    = VALUE_W'(hu) * 10'd100;

      // A teen takes the tens slot and suppresses the units clip
      list.mask[SLOT_TENS]          = (te != 4'd0);
      list.slot[SLOT_TENS].kind     = KIND_NUMERAL;
      list.slot[SLOT_TENS].value    = (te == 4'd1) ? (10'd10 + VALUE_W'(un))
                                                   : (VALUE_W'(te) * 10'd10);

      list.mask[SLOT_UNITS]         = (te != 4'd1) && (un != 4'd0);
      list.slot[SLOT_UNITS].kind    = KIND_NUMERAL;
      list.slot[SLOT_UNITS].value   = VALUE_W'(un);

      list.mask[SLOT_NOUN]          = 1'b1;
      list.slot[SLOT_NOUN].kind     = KIND_CURRENCY;
      list.slot[SLOT_NOUN].value    = noun_form(te, un);
    end
  end

endmodule

`default_nettype wire

### hdl/atsw_serial.sv
`timescale 1ns / 1ps
`default_nettype none

module atsw_serial (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire atsw_pkg::list_t               list,
  input  wire logic                          list_valid,
  output logic                               list_ready,
  output logic [atsw_pkg::KIND_W-1:0]        word_kind,
  output logic [atsw_pkg::VALUE_W-1:0]       word_value,
  output logic                               last_word,
  output logic                               word_valid,
  input  wire logic                          word_ready
);
  import atsw_pkg::*;

  logic [SLOT_COUNT-1:0]  mask;
  logic [SLOT_COUNT-1:0]  mask_next;
  slot_t [SLOT_COUNT-1:0] slots;
  logic [SLOT_COUNT-1:0]  pick;
  logic [SLOT_COUNT-1:0]  rest;
  slot_t                  sel;

  // Lowest pending slot plays first
  assign pick      = mask & (~mask + SLOT_COUNT'(1));
  assign rest      = mask & ~pick;
  assign word_valid = |mask;
  assign last_word  = (rest == '0);

  always_comb begin
    sel = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (pick[i]) begin
        sel = slots[i];
      end
    end
  end

  assign word_kind  = sel.kind;
  assign word_value = sel.value;

  // Take the next list as the last clip of this one leaves
  assign list_ready = !word_valid || (word_ready && last_word);

  always_comb begin
    mask_next = mask;
    if (list_ready) begin
      mask_next = list_valid ? list.mask : '0;
    end else if (word_valid && word_ready) begin
      mask_next = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (list_ready && list_valid) begin
      slots <= list.slot;
    end
  end

endmodule

`default_nettype wire

### hdl/amount_to_spoken_words.sv
// Amount announcer: turns a whole amount into the ordered spoken clips.
// Input channel: amount with amount_valid / amount_ready; one transaction
// is one amount. Output channel: word_kind, word_value, last_word with
// word_valid / word_ready; one transaction is one clip, and last_word marks
// the final clip of an amount.
// The first clip of an amount is valid once the amount has passed the input
// register and then the clip-list register.
// Throughput: one clip per cycle while word_ready is high; an amount gives
// 1 to 6 clips. The clip list register is reloaded in the same cycle the
// last clip of the previous amount leaves, so amounts follow each other
// with no gap.
// Amounts above 9999 give a single overflow clip.
// Reset empties the input register and the clip list; nothing else is kept.
// When the receiver stalls, the current clip holds, the list behind it
// holds, and amount_ready drops once the input register is also full.
`timescale 1ns / 1ps
`default_nettype none
`include "amount_to_spoken_words_defines.svh"

module amount_to_spoken_words (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [atsw_pkg::AMOUNT_W-1:0] amount,
  input  wire logic                          amount_valid,
  output logic                               amount_ready,
  output logic [atsw_pkg::KIND_W-1:0]        word_kind,
  output logic [atsw_pkg::VALUE_W-1:0]       word_value,
  output logic                               last_word,
  output logic                               word_valid,
  input  wire logic                          word_ready
);
  import atsw_pkg::*;

  list_t list;
  logic  list_valid;
  logic  list_ready;

  // Digit split and clip slot fill
  atsw_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .amount       (amount),
    .amount_valid (amount_valid),
    .amount_ready (amount_ready),
    .list         (list),
    .list_valid   (list_valid),
    .list_ready   (list_ready)
  );

  // Clip playout, one per cycle while word_ready is high
  atsw_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .list       (list),
    .list_valid (list_valid),
    .list_ready (list_ready),
    .word_kind  (word_kind),
    .word_value (word_value),
    .last_word  (last_word),
    .word_valid (word_valid),
    .word_ready (word_ready)
  );

  // Only the currency noun or the overflow clip closes an amount
  `ATSW_ASSERT_IMPL(a_last_kind, word_valid, last_word == ((word_kind == KIND_CURRENCY) || (word_kind == KIND_OVERFLOW)), "last_word disagrees with clip kind")
  // An overflow clip stands alone
  `ATSW_ASSERT_IMPL(a_ovf_alone, word_valid && (word_kind == KIND_OVERFLOW), last_word && (word_value == '0), "overflow clip malformed")
  // A clip that is not last is followed by another clip
  `ATSW_ASSERT_NEXT(a_more_clips, word_valid && word_ready && !last_word, word_valid, "clips lost inside an amount")
  // Input stalls only while clips are waiting on the receiver
  `ATSW_ASSERT_IMPL(a_stall_cause, !amount_ready, word_valid && !(word_ready && last_word), "input stalled without output back-pressure")

endmodule

`default_nettype wire

### bench/amount_to_spoken_words_tb.sv
`timescale 1ns / 1ps

module amount_to_spoken_words_tb;
  import atsw_pkg::*;

  localparam int RANDOM_AMOUNTS = 235;
  localparam int STALL_LIMIT    = 5000;
  localparam int TAIL_CYCLES    = 12;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } clip_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [AMOUNT_W-1:0] amount = '0;
  logic                amount_valid = 1'b0;
  logic                amount_ready;
  logic [KIND_W-1:0]   word_kind;
  logic [VALUE_W-1:0]  word_value;
  logic                last_word;
  logic                word_valid;
  logic                word_ready = 1'b0;

  logic [AMOUNT_W-1:0] amount_backlog[$];
  clip_t               clips_due[$];
  int                  amounts_taken = 0;
  int                  clips_seen = 0;
  int                  error_count = 0;
  int                  quiet_cycles = 0;

  amount_to_spoken_words dut (
    .clk          (clk),
    .rst          (rst),
    .amount       (amount),
    .amount_valid (amount_valid),
    .amount_ready (amount_ready),
    .word_kind    (word_kind),
    .word_value   (word_value),
    .last_word    (last_word),
    .word_valid   (word_valid),
    .word_ready   (word_ready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // Grammatical form of a noun after the given tens and units digits
  function automatic logic [VALUE_W-1:0] noun_form_of(input int tens, input int units);
    if (tens == 1) return FORM_GEN_PLUR;
    if (units == 1) return FORM_NOM_SING;
    if (units >= 2 && units <= 4) return FORM_GEN_SING;
    return FORM_GEN_PLUR;
  endfunction

  function automatic clip_t make_clip(input logic [KIND_W-1:0] kind, input int value);
    clip_t c;
    c.kind  = kind;
    c.value = VALUE_W'(value);
    c.last  = 1'b0;
    return c;
  endfunction

  // Spell one amount into its clip sequence and queue it for checking
  function automatic void spell_amount(input logic [AMOUNT_W-1:0] amt);
    clip_t words[$];
    clip_t c;
    int    th;
    int    hu;
    int    te;
    int    un;
    if (amt > AMOUNT_MAX) begin
      c = make_clip(KIND_OVERFLOW, 0);
      c.last = 1'b1;
      clips_due.push_back(c);
      return;
    end
    un = amt % 10;
    te = (amt / 10) % 10;
    hu = (amt / 100) % 10;
    th = amt / 1000;
    if (th != 0) begin
      words.push_back(make_clip(th <= 2 ? KIND_FEM_NUMERAL : KIND_NUMERAL, th));
      words.push_back(make_clip(KIND_THOUSAND, noun_form_of(0, th)));
    end
    if (hu != 0) words.push_back(make_clip(KIND_NUMERAL, hu * 100));
    if (te == 1) begin
      words.push_back(make_clip(KIND_NUMERAL, 10 + un));
    end else begin
      if (te != 0) words.push_back(make_clip(KIND_NUMERAL, te * 10));
      if (un != 0) words.push_back(make_clip(KIND_NUMERAL, un));
    end
    words.push_back(make_clip(KIND_CURRENCY, noun_form_of(te, un)));
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) clips_due.push_back(words[i]);
  endfunction

  // Drive amounts from the backlog; predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      amount_valid <= 1'b0;
    end else begin
      if (amount_valid && amount_ready) begin
        spell_amount(amount);
        amounts_taken <= amounts_taken + 1;
      end
      if (!amount_valid || amount_ready) begin
        if (amount_backlog.size() > 0 &&
            ((amounts_taken >= 120 && amounts_taken < 180) || $urandom_range(99) >= 10)) begin
          amount       <= amount_backlog.pop_front();
          amount_valid <= 1'b1;
        end else begin
          amount_valid <= 1'b0;
        end
      end
    end
  end

  // Check each clip against the oldest prediction; stall the output at random
  always @(posedge clk) begin
    clip_t want;
    if (rst) begin
      word_ready <= 1'b0;
    end else begin
      if (word_valid && word_ready) begin
        clips_seen <= clips_seen + 1;
        if (clips_due.size() == 0) begin
          error_count <= error_count + 1;
          if (error_count < REPORT_LIMIT)
            $display("unexpected clip: kind %0d value %0d last %0b",
                     word_kind, word_value, last_word);
        end else begin
          want = clips_due.pop_front();
          if (want.kind !== word_kind || want.value !== word_value ||
              want.last !== last_word) begin
            error_count <= error_count + 1;
            if (error_count < REPORT_LIMIT)
              $display("clip mismatch: expected kind %0d value %0d last %0b, got kind %0d value %0d last %0b",
                       want.kind, want.value, want.last, word_kind, word_value, last_word);
          end
        end
      end
      word_ready <= (clips_seen >= 400 && clips_seen < 600) || $urandom_range(99) >= 10;
    end
  end

  // Count cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (rst || (amount_valid && amount_ready) || (word_valid && word_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("amount_to_spoken_words_tb: errors");
    $finish;
  end

  // Fill the backlog, then wait for every clip to drain
  initial begin
    int total;
    int pick;
    logic [AMOUNT_W-1:0] directed[] = '{
      14'd0, 14'd1, 14'd2, 14'd5, 14'd10, 14'd11, 14'd19, 14'd20, 14'd21,
      14'd100, 14'd101, 14'd111, 14'd1000, 14'd1001, 14'd2000, 14'd2002,
      14'd3004, 14'd4999, 14'd5000, 14'd1012, 14'd2112, 14'd9999,
      14'd10000, 14'd16383, 14'd8192
    };
    foreach (directed[i]) amount_backlog.push_back(directed[i]);
    for (int i = 0; i < RANDOM_AMOUNTS; i++) begin
      pick = $urandom_range(99);
      if (pick < 10)
        amount_backlog.push_back(AMOUNT_W'($urandom_range(16383, 10000)));
      else if (pick < 25)
        amount_backlog.push_back(AMOUNT_W'($urandom_range(99)));
      else
        amount_backlog.push_back(AMOUNT_W'($urandom_range(9999)));
    end
    total = amount_backlog.size();

    while (amounts_taken < total) @(posedge clk);
    while (clips_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && clips_due.size() == 0) begin
      $display("amount_to_spoken_words_tb: clean");
    end else begin
      $display("amount_to_spoken_words_tb: errors");
    end
    $finish;
  end

endmodule
